@@ hw/rtl/dtq_pkg.sv @@
package dtq_pkg;

	localparam int NUM_TIMERS = 16;
	localparam int ID_W       = 4;
	localparam int DUR_W      = 32;
	localparam int NPT_W      = 30;
	localparam int TIME_W     = 64;
	localparam int MAX_OUT    = 16;
	localparam int CNT_W      = $clog2(MAX_OUT + 1);
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [NPT_W-1:0] NPT_RESET = NPT_W'(1000000);

	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_STOP  = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	typedef enum logic [1:0] {
		OP_START,
		OP_STOP,
		OP_TICK
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [ID_W-1:0]  id;
		logic [DUR_W-1:0] dur;
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_SUM,
		ST_SCAN,
		ST_FOUND,
		ST_FLUSH
	} state_t;

endpackage

@@ hw/rtl/dtq_front.sv @@
module dtq_front
	import dtq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       req_type,
	input  logic [ID_W-1:0]  timer_id,
	input  logic [DUR_W-1:0] duration_ns,
	output logic             req_valid,
	output req_t             req,
	input  logic             req_pop
);

	req_t               fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               keep;
	logic               id_ok;
	logic               push;
	logic               pop;
	req_t               cls;

	// classify: drop unused codes and out-of-range timers
	assign id_ok = (32'(timer_id) < NUM_TIMERS);

	always_comb begin
		keep   = 1'b0;
		cls.op = OP_TICK;
		case (req_type)
			REQ_START: begin
				keep   = id_ok;
				cls.op = OP_START;
			end
			REQ_STOP: begin
				keep   = id_ok;
				cls.op = OP_STOP;
			end
			REQ_TICK: begin
				keep   = 1'b1;
				cls.op = OP_TICK;
			end
			default: begin
				keep   = 1'b0;
				cls.op = OP_TICK;
			end
		endcase
		cls.id  = timer_id;
		cls.dur = duration_ns;
	end

	assign in_stall  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign push      = in_valid && !in_stall && keep;
	assign req_valid = (count_q != '0);
	assign pop       = req_pop && req_valid;
	assign req       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/dtq_back.sv @@
module dtq_back
	import dtq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [NPT_W-1:0] ns_per_tick,
	input  logic             req_valid,
	input  req_t             req,
	output logic             req_pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [ID_W-1:0]  expired_id,
	output logic             last_of_run
);

	localparam int NSLOT = 2**ID_W;

	state_t              state_q, state_d;
	req_t                cur_q;
	logic [TIME_W-1:0]   tick_q;
	logic [TIME_W-1:0]   now_q;
	logic [61:0]         plo_q;
	logic [31:0]         phi_q;
	logic [TIME_W-1:0]   dl_q [NSLOT];
	logic [NSLOT-1:0]    armed_q;
	logic [ID_W-1:0]     idx_q;
	logic                found_q;
	logic [ID_W-1:0]     best_q;
	logic [TIME_W-1:0]   best_dl_q;
	logic                pend_q;
	logic [ID_W-1:0]     pend_id_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                ov_q;
	logic [ID_W-1:0]     oid_q;
	logic                olast_q;
	logic [TIME_W-1:0]   dl_rd;
	logic                hit;
	logic                slot_free;
	logic                scan_end;
	logic [61:0]         mul_lo;
	logic [61:0]         mul_hi;

	assign slot_free   = !ov_q || !out_stall;
	assign out_valid   = ov_q;
	assign expired_id  = oid_q;
	assign last_of_run = olast_q;
	assign dl_rd       = dl_q[idx_q];
	assign hit         = armed_q[idx_q] && (dl_rd <= now_q) && (!found_q || dl_rd < best_dl_q);
	assign scan_end    = (idx_q == ID_W'(NUM_TIMERS - 1));
	assign mul_lo      = tick_q[31:0] * ns_per_tick;
	assign mul_hi      = tick_q[63:32] * ns_per_tick;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid && req.op != OP_STOP) begin
					state_d = ST_MUL_LO;
				end
			end
			ST_MUL_LO: state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_SUM;
			ST_SUM: begin
				state_d = (cur_q.op == OP_TICK) ? ST_SCAN : ST_IDLE;
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_FOUND;
				end
			end
			ST_FOUND: begin
				if (!found_q) begin
					state_d = pend_q ? ST_FLUSH : ST_IDLE;
				end else if (!pend_q || slot_free) begin
					state_d = (cnt_q == CNT_W'(MAX_OUT - 1)) ? ST_FLUSH : ST_SCAN;
				end
			end
			ST_FLUSH: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_pop = (state_q == ST_IDLE);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			cur_q <= req;
		end
		plo_q <= mul_lo;
		phi_q <= mul_hi[31:0];
		if (state_q == ST_SUM) begin
			if (cur_q.op == OP_START && !armed_q[cur_q.id]) begin
				dl_q[cur_q.id] <= {2'b00, plo_q} + {phi_q, 32'd0} + TIME_W'(cur_q.dur);
			end else begin
				now_q <= {2'b00, plo_q} + {phi_q, 32'd0};
			end
		end
		if (state_q == ST_SCAN && hit) begin
			best_q    <= idx_q;
			best_dl_q <= dl_rd;
		end
		if (state_q == ST_FOUND && found_q && (!pend_q || slot_free)) begin
			pend_id_q <= best_q;
		end
		if (slot_free) begin
			if (state_q == ST_FOUND && found_q && pend_q) begin
				oid_q   <= pend_id_q;
				olast_q <= 1'b0;
			end else if (state_q == ST_FLUSH) begin
				oid_q   <= pend_id_q;
				olast_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tick_q  <= '0;
			armed_q <= '0;
			idx_q   <= '0;
			found_q <= 1'b0;
			pend_q  <= 1'b0;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						if (req.op == OP_STOP) begin
							armed_q[req.id] <= 1'b0;
						end
						if (req.op == OP_TICK) begin
							tick_q <= tick_q + 1'b1;
						end
					end
					idx_q   <= '0;
					found_q <= 1'b0;
					pend_q  <= 1'b0;
					cnt_q   <= '0;
				end
				ST_SUM: begin
					if (cur_q.op == OP_START) begin
						armed_q[cur_q.id] <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (hit) begin
						found_q <= 1'b1;
					end
					idx_q <= scan_end ? '0 : idx_q + 1'b1;
				end
				ST_FOUND: begin
					if (found_q && (!pend_q || slot_free)) begin
						armed_q[best_q] <= 1'b0;
						pend_q          <= 1'b1;
						cnt_q           <= cnt_q + 1'b1;
						found_q         <= 1'b0;
					end
				end
				default: begin
				end
			endcase
			if (slot_free) begin
				ov_q <= (state_q == ST_FOUND && found_q && pend_q) || (state_q == ST_FLUSH);
			end
		end
	end

endmodule

@@ hw/rtl/deadline_timer_queue.sv @@
// Deadline-ordered bank of one-shot timers. Requests (start, stop, tick) enter a
// four-deep request queue and are carried out one at a time by the back end. A stop
// is done in the idle state. A start forms the current time (tick count times
// ns_per_tick, as two 32x30 partial products) and then adds the duration to give
// the deadline. A tick forms the current time the same way, then makes one pass (a
// scan of the timer table plus a select step) per expired timer, then one more
// pass that finds none and, if anything expired, a flush step to release the last
// result; the sixteenth expiration skips the closing pass. Output stalls can hold
// the back end.
// Expirations leave in deadline order, ties to the lower timer number, with
// last_of_run set on the final one of a tick; a tick with nothing due gives no
// result. Write ns_per_tick only while the block is idle.
module deadline_timer_queue
	import dtq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [NPT_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       req_type,
	input  logic [ID_W-1:0]  timer_id,
	input  logic [DUR_W-1:0] duration_ns,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [ID_W-1:0]  expired_id,
	output logic             last_of_run
);

	logic [NPT_W-1:0] npt_q;
	logic             req_valid;
	logic             req_pop;
	req_t             req;

	// hold the tick length until rewritten
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			npt_q <= NPT_RESET;
		end else if (cfg_we) begin
			npt_q <= cfg_wdata;
		end
	end

	// accept and classify requests, queue them
	dtq_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.timer_id    (timer_id),
		.duration_ns (duration_ns),
		.req_valid   (req_valid),
		.req         (req),
		.req_pop     (req_pop)
	);

	// advance time, arm, disarm and scan for due timers
	dtq_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.ns_per_tick (npt_q),
		.req_valid   (req_valid),
		.req         (req),
		.req_pop     (req_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.expired_id  (expired_id),
		.last_of_run (last_of_run)
	);

endmodule
